// ----- rtl/assert_macros.svh -----
// Assertion helpers used by script_flow_control_unit_core.
// Each macro expands to one labeled concurrent assertion clocked by clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SFCU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define SFCU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sfcu_pkg.sv -----
// ----------------------------------------------------------------------------
// sfcu_pkg
// Types, sizes and codes for the script flow control unit.
// ----------------------------------------------------------------------------
package sfcu_pkg;

  // Sizing.
  localparam int SCRIPT_SLOTS = 128;
  localparam int STACK_DEPTH  = 4;
  localparam int SLOT_W       = (SCRIPT_SLOTS > 1) ? $clog2(SCRIPT_SLOTS) : 1;
  localparam int LVL_W        = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DEPTH_W      = $clog2(STACK_DEPTH + 1);

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int SLOTF_W = 7;
  localparam int OPC_W   = 8;
  localparam int ADDR_W  = 16;
  localparam int VAL_W   = 16;
  localparam int CNT_W   = 8;
  localparam int NDEP_W  = 3;

  // Item commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_FLOW  = 3'd0,
    CMD_START = 3'd1,
    CMD_LOAD  = 3'd2,
    CMD_AND   = 3'd3,
    CMD_SUB   = 3'd4
  } cmd_t;

  // Flow opcodes.
  localparam logic [OPC_W-1:0] OP_RET      = 8'hFF;
  localparam logic [OPC_W-1:0] OP_CALL     = 8'hFC;
  localparam logic [OPC_W-1:0] OP_JUMP     = 8'hFB;
  localparam logic [OPC_W-1:0] OP_BR_ZERO  = 8'hFA;
  localparam logic [OPC_W-1:0] OP_BR_NEG   = 8'hF9;
  localparam logic [OPC_W-1:0] OP_BR_POS   = 8'hF5;
  localparam logic [OPC_W-1:0] OP_LOOP     = 8'hF8;
  localparam logic [OPC_W-1:0] OP_LOOP_END = 8'hF7;
  localparam logic [OPC_W-1:0] OP_BREAK    = 8'hF6;
  localparam logic [OPC_W-1:0] OP_REL      = 8'hF4;
  localparam logic [OPC_W-1:0] OP_REL_ZERO = 8'hF3;
  localparam logic [OPC_W-1:0] OP_REL_NEG  = 8'hF2;

  // One input item.
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SLOTF_W-1:0] script_slot;
    logic [OPC_W-1:0]   opcode;
    logic [ADDR_W-1:0]  operand;
    logic [ADDR_W-1:0]  next_pc;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [ADDR_W-1:0]       fetch_address;
    logic                    script_ended;
    logic                    stack_overflow;
    logic signed [VAL_W-1:0] value_out;
    logic [NDEP_W-1:0]       nesting_depth;
  } out_item_t;

  // Everything one slot keeps, stored as one memory row.
  typedef struct packed {
    logic [ADDR_W-1:0]                  pc;
    logic [DEPTH_W-1:0]                 depth;
    logic [VAL_W-1:0]                   value;
    logic [STACK_DEPTH-1:0][ADDR_W-1:0] ret;
    logic [STACK_DEPTH-1:0][CNT_W-1:0]  cnt;
  } slot_row_t;

endpackage

// ----- rtl/sfcu_in_if.sv -----
// ----------------------------------------------------------------------------
// sfcu_in_if
// Command channel: valid/ready handshake with one command item as payload.
// ----------------------------------------------------------------------------
interface sfcu_in_if;
  logic                               valid;
  logic                               ready;
  logic [sfcu_pkg::CMD_W-1:0]         command;
  logic [sfcu_pkg::SLOTF_W-1:0]       script_slot;
  logic [sfcu_pkg::OPC_W-1:0]         opcode;
  logic [sfcu_pkg::ADDR_W-1:0]        operand;
  logic [sfcu_pkg::ADDR_W-1:0]        next_pc;

  modport source (output valid, command, script_slot, opcode, operand, next_pc,
                  input ready);
  modport sink   (input valid, command, script_slot, opcode, operand, next_pc,
                  output ready);
endinterface

// ----- rtl/sfcu_out_if.sv -----
// ----------------------------------------------------------------------------
// sfcu_out_if
// Result channel: valid/ready handshake with one result item as payload.
// ----------------------------------------------------------------------------
interface sfcu_out_if;
  logic                               valid;
  logic                               ready;
  logic [sfcu_pkg::ADDR_W-1:0]        fetch_address;
  logic                               script_ended;
  logic                               stack_overflow;
  logic signed [sfcu_pkg::VAL_W-1:0]  value_out;
  logic [sfcu_pkg::NDEP_W-1:0]        nesting_depth;

  modport source (output valid, fetch_address, script_ended, stack_overflow,
                  value_out, nesting_depth, input ready);
  modport sink   (input valid, fetch_address, script_ended, stack_overflow,
                  value_out, nesting_depth, output ready);
endinterface

// ----- rtl/sfcu_step.sv -----
// ----------------------------------------------------------------------------
// sfcu_step
// Executes one command against one slot row: new row and result item.
// ----------------------------------------------------------------------------
module sfcu_step (
  input  sfcu_pkg::in_item_t  item,
  input  sfcu_pkg::slot_row_t row,
  output sfcu_pkg::slot_row_t row_nxt,
  output sfcu_pkg::out_item_t res
);

  logic [sfcu_pkg::DEPTH_W-1:0] depth_c;
  logic [sfcu_pkg::DEPTH_W-1:0] depth_n;
  logic [sfcu_pkg::LVL_W-1:0]   push_idx;
  logic [sfcu_pkg::LVL_W-1:0]   top_idx;
  logic                         full;
  logic                         empty;
  logic                         is_zero;
  logic                         is_neg;
  logic [sfcu_pkg::ADDR_W-1:0]  rel_pc;
  logic [sfcu_pkg::ADDR_W-1:0]  pc_n;
  logic [sfcu_pkg::VAL_W-1:0]   val_n;
  logic [sfcu_pkg::CNT_W-1:0]   cnt_dec;
  logic [sfcu_pkg::VAL_W-1:0]   opnd_byte;
  logic                         ended;
  logic                         overflow;

  // Stored depth is clamped to the stack size before use.
  assign depth_c  = (row.depth > sfcu_pkg::DEPTH_W'(sfcu_pkg::STACK_DEPTH)) ?
                    sfcu_pkg::DEPTH_W'(sfcu_pkg::STACK_DEPTH) : row.depth;
  assign full     = (depth_c == sfcu_pkg::DEPTH_W'(sfcu_pkg::STACK_DEPTH));
  assign empty    = (depth_c == '0);
  assign push_idx = sfcu_pkg::LVL_W'(depth_c);
  assign top_idx  = sfcu_pkg::LVL_W'(depth_c - sfcu_pkg::DEPTH_W'(1));
  assign is_zero  = (row.value == '0);
  assign is_neg   = row.value[sfcu_pkg::VAL_W-1];
  assign cnt_dec  = row.cnt[top_idx] - sfcu_pkg::CNT_W'(1);

  // Relative target: next_pc plus the sign-extended low operand byte.
  assign rel_pc    = item.next_pc + {{8{item.operand[7]}}, item.operand[7:0]};
  assign opnd_byte = {8'h00, item.operand[7:0]};

  // Command decode and flow execution.
  always_comb begin
    row_nxt  = row;
    pc_n     = row.pc;
    depth_n  = depth_c;
    val_n    = row.value;
    ended    = 1'b0;
    overflow = 1'b0;
    case (sfcu_pkg::cmd_t'(item.command))
      sfcu_pkg::CMD_FLOW: begin
        pc_n = item.next_pc;
        case (item.opcode)
          sfcu_pkg::OP_RET: begin
            if (empty) begin
              ended = 1'b1;
            end else begin
              depth_n = depth_c - sfcu_pkg::DEPTH_W'(1);
              pc_n    = row.ret[top_idx];
            end
          end
          sfcu_pkg::OP_CALL: begin
            if (full) begin
              overflow = 1'b1;
            end else begin
              row_nxt.ret[push_idx] = item.next_pc;
              depth_n = depth_c + sfcu_pkg::DEPTH_W'(1);
              pc_n    = item.operand;
            end
          end
          sfcu_pkg::OP_JUMP:    pc_n = item.operand;
          sfcu_pkg::OP_BR_ZERO: if (is_zero) pc_n = item.operand;
          sfcu_pkg::OP_BR_NEG:  if (is_neg) pc_n = item.operand;
          sfcu_pkg::OP_BR_POS:  if (!is_neg) pc_n = item.operand;
          sfcu_pkg::OP_LOOP: begin
            if (full) begin
              overflow = 1'b1;
            end else begin
              row_nxt.cnt[push_idx] = item.operand[7:0];
              row_nxt.ret[push_idx] = item.next_pc;
              depth_n = depth_c + sfcu_pkg::DEPTH_W'(1);
            end
          end
          sfcu_pkg::OP_LOOP_END: begin
            if (!empty) begin
              row_nxt.cnt[top_idx] = cnt_dec;
              if (cnt_dec != '0) begin
                pc_n = row.ret[top_idx];
              end else begin
                depth_n = depth_c - sfcu_pkg::DEPTH_W'(1);
              end
            end
          end
          sfcu_pkg::OP_BREAK: if (!empty) depth_n = depth_c - sfcu_pkg::DEPTH_W'(1);
          sfcu_pkg::OP_REL:      pc_n = rel_pc;
          sfcu_pkg::OP_REL_ZERO: if (is_zero) pc_n = rel_pc;
          sfcu_pkg::OP_REL_NEG:  if (is_neg) pc_n = rel_pc;
          default: ;
        endcase
      end
      sfcu_pkg::CMD_START: begin
        pc_n    = item.operand;
        depth_n = '0;
        val_n   = '0;
      end
      sfcu_pkg::CMD_LOAD: begin
        pc_n  = item.next_pc;
        val_n = opnd_byte;
      end
      sfcu_pkg::CMD_AND: begin
        pc_n  = item.next_pc;
        val_n = row.value & opnd_byte;
      end
      sfcu_pkg::CMD_SUB: begin
        pc_n  = item.next_pc;
        val_n = row.value - opnd_byte;
      end
      default: ;
    endcase
    row_nxt.pc    = pc_n;
    row_nxt.depth = depth_n;
    row_nxt.value = val_n;
  end

  // Result item.
  assign res.fetch_address  = pc_n;
  assign res.script_ended   = ended;
  assign res.stack_overflow = overflow;
  assign res.value_out      = val_n;
  assign res.nesting_depth  = sfcu_pkg::NDEP_W'(depth_n);

endmodule

// ----- rtl/script_flow_control_unit_core.sv -----
// ----------------------------------------------------------------------------
// script_flow_control_unit_core
// Flow control for many music scripts: per-slot program counter, return
// stack with loop counts, nesting depth and condition value.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload
//   in_ch    sink       command, script_slot, opcode, operand, next_pc
//   out_ch   source     fetch_address, script_ended, stack_overflow,
//                       value_out, nesting_depth
//
// One item per cycle is sustained while out_ch is ready. The slot row is
// read into the input register at the item's transfer, and the result
// register is loaded when the execute stage advances.
// All slot state lives in one memory row per slot, read at one address and
// written at one address each cycle; a slot hit by two items in a row takes
// the row just written through a bypass register.
// Reset clears only the pipeline valid flags and the bypass flag; slot
// rows are undefined until a slot is started, so no clearing pass runs.
// A stalled result holds the execute stage, and the input then stalls too.
module script_flow_control_unit_core (
  input  logic              clk,
  input  logic              rst_n,
  sfcu_in_if.sink           in_ch,
  sfcu_out_if.source        out_ch
);

  `include "assert_macros.svh"

  sfcu_pkg::slot_row_t mem_r [sfcu_pkg::SCRIPT_SLOTS];

  logic                       s1_valid_r;
  logic                       s1_valid_nxt;
  sfcu_pkg::in_item_t         s1_item_r;
  sfcu_pkg::slot_row_t        rd_row_r;
  sfcu_pkg::slot_row_t        wr_row_r;
  logic                       fwd_r;
  logic                       fwd_nxt;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  sfcu_pkg::out_item_t        out_item_r;

  sfcu_pkg::in_item_t         in_item;
  sfcu_pkg::slot_row_t        cur_row;
  sfcu_pkg::slot_row_t        new_row;
  sfcu_pkg::out_item_t        step_res;
  logic                       in_xfer;
  logic                       s1_adv;
  logic [sfcu_pkg::SLOT_W-1:0] in_idx;
  logic [sfcu_pkg::SLOT_W-1:0] s1_idx;

  // Payload gathering and slot indexes.
  assign in_item.command     = in_ch.command;
  assign in_item.script_slot = in_ch.script_slot;
  assign in_item.opcode      = in_ch.opcode;
  assign in_item.operand     = in_ch.operand;
  assign in_item.next_pc     = in_ch.next_pc;
  assign in_idx = in_ch.script_slot[sfcu_pkg::SLOT_W-1:0];
  assign s1_idx = s1_item_r.script_slot[sfcu_pkg::SLOT_W-1:0];

  // Handshake: execute advances when the result register is free or drains.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // The row written in the same cycle as this item's read is bypassed.
  assign cur_row = fwd_r ? wr_row_r : rd_row_r;

  sfcu_step u_step (
    .item    (s1_item_r),
    .row     (cur_row),
    .row_nxt (new_row),
    .res     (step_res)
  );

  // Control next state.
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      fwd_nxt      = s1_adv && (s1_idx == in_idx);
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      fwd_nxt      = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Slot memory, input register and result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
      rd_row_r  <= mem_r[in_idx];
    end
    if (s1_adv) begin
      mem_r[s1_idx] <= new_row;
      wr_row_r      <= new_row;
      out_item_r    <= step_res;
    end
  end

  // Result channel.
  assign out_ch.valid          = out_valid_r;
  assign out_ch.fetch_address  = out_item_r.fetch_address;
  assign out_ch.script_ended   = out_item_r.script_ended;
  assign out_ch.stack_overflow = out_item_r.stack_overflow;
  assign out_ch.value_out      = out_item_r.value_out;
  assign out_ch.nesting_depth  = out_item_r.nesting_depth;

  // Pipeline checks.
  `SFCU_ASSERT(a_xfer_fills_s1, in_xfer |=> s1_valid_r, "accepted item missing from execute stage")
  `SFCU_ASSERT(a_s1_holds, s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r), "stalled item lost or changed")
  `SFCU_ASSERT(a_adv_fills_out, s1_adv |=> out_valid_r, "executed item gave no result")
  `SFCU_ASSERT_ALWAYS(a_fwd_only_busy, fwd_r |-> s1_valid_r, "bypass set with empty execute stage")
  `SFCU_ASSERT(a_empty_ready, !s1_valid_r |-> in_ch.ready, "idle block refuses input")

endmodule
